@@ hdl/cqas_pkg.sv @@
// Shared types, codes and reset values for the command queue sequencer.
`default_nettype none
package cqas_pkg;

   // input item kinds
   localparam logic [1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [1:0] KIND_MESSAGE = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;
   localparam logic [1:0] KIND_CLEAR   = 2'd3;

   // request classes
   localparam logic [1:0] CLASS_RESET  = 2'd0;
   localparam logic [1:0] CLASS_SOURCE = 2'd1;
   localparam logic [1:0] CLASS_QUERY  = 2'd2;
   localparam logic [1:0] CLASS_PLAIN  = 2'd3;

   // received message classes
   localparam logic [2:0] RX_ACK   = 3'd0;
   localparam logic [2:0] RX_ERROR = 3'd1;
   localparam logic [2:0] RX_INIT  = 3'd2;
   localparam logic [2:0] RX_ASYNC = 3'd3;
   localparam logic [2:0] RX_OTHER = 3'd4;

   // result kinds
   localparam logic [1:0] OUT_SEND     = 2'd0;
   localparam logic [1:0] OUT_RESPONSE = 2'd1;
   localparam logic [1:0] OUT_ASYNC    = 2'd2;
   localparam logic [1:0] OUT_OVERFLOW = 2'd3;

   // register indexes
   localparam logic [2:0] REG_RESET_WAIT    = 3'd0;
   localparam logic [2:0] REG_ACK_WAIT      = 3'd1;
   localparam logic [2:0] REG_QUERY_WAIT    = 3'd2;
   localparam logic [2:0] REG_SOURCE_SETTLE = 3'd3;
   localparam logic [2:0] REG_STATUS_ID     = 3'd4;

   localparam logic [11:0] RESET_WAIT_DEFAULT    = 12'd3000;
   localparam logic [11:0] ACK_WAIT_DEFAULT      = 12'd33;
   localparam logic [11:0] QUERY_WAIT_DEFAULT    = 12'd100;
   localparam logic [11:0] SOURCE_SETTLE_DEFAULT = 12'd200;
   localparam logic [7:0]  STATUS_ID_DEFAULT     = 8'd66;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [6:0] {
      HS_READY     = 7'b0000001,
      HS_INIT      = 7'b0000010,
      HS_ACK       = 7'b0000100,
      HS_RESP      = 7'b0001000,
      HS_SRC_ACK   = 7'b0010000,
      HS_SRC_DELAY = 7'b0100000,
      HS_STUCK     = 7'b1000000
   } hs_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  msg_id;
      logic [15:0] msg_param;
      logic [1:0]  req_class;
      logic [2:0]  rx_class;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_id;
      logic [15:0] out_param;
      logic        out_feedback;
      logic        out_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  req_class;
      logic [15:0] msg_param;
      logic [7:0]  msg_id;
   } ring_entry_type;

   localparam int RING_W = $bits(ring_entry_type);

   typedef struct packed {
      logic [11:0] reset_wait;
      logic [11:0] ack_wait;
      logic [11:0] query_wait;
      logic [11:0] source_settle;
      logic [7:0]  status_id;
   } cfg_type;

endpackage
`default_nettype wire

@@ hdl/cqas_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module cqas_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata <= mem[addr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/cqas_csr.sv @@
// Configuration registers behind an APB-style port.
`default_nettype none
module cqas_csr
   import cqas_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] index;
   logic       write;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign write      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         case (index)
            REG_RESET_WAIT:    cfg_in.reset_wait    = csr_pwdata[11:0];
            REG_ACK_WAIT:      cfg_in.ack_wait      = csr_pwdata[11:0];
            REG_QUERY_WAIT:    cfg_in.query_wait    = csr_pwdata[11:0];
            REG_SOURCE_SETTLE: cfg_in.source_settle = csr_pwdata[11:0];
            REG_STATUS_ID:     cfg_in.status_id     = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_RESET_WAIT:    csr_prdata = {20'd0, cfg_ff.reset_wait};
         REG_ACK_WAIT:      csr_prdata = {20'd0, cfg_ff.ack_wait};
         REG_QUERY_WAIT:    csr_prdata = {20'd0, cfg_ff.query_wait};
         REG_SOURCE_SETTLE: csr_prdata = {20'd0, cfg_ff.source_settle};
         REG_STATUS_ID:     csr_prdata = {24'd0, cfg_ff.status_id};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_wait    <= RESET_WAIT_DEFAULT;
         cfg_ff.ack_wait      <= ACK_WAIT_DEFAULT;
         cfg_ff.query_wait    <= QUERY_WAIT_DEFAULT;
         cfg_ff.source_settle <= SOURCE_SETTLE_DEFAULT;
         cfg_ff.status_id     <= STATUS_ID_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cqas_seq.sv @@
// Sequencer: handshake state, wait timer, ring pointers and result register.
`default_nettype none
module cqas_seq
   import cqas_pkg::*;
#(
   parameter int QUEUE_SLOTS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire req_type                        req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output rsp_type                             rsp_data,
   input  wire cfg_type                        cfg,
   output logic                                ram_we,
   output logic                                ram_re,
   output logic      [$clog2(QUEUE_SLOTS)-1:0] ram_addr,
   output logic      [RING_W-1:0]              ram_wdata,
   input  wire logic [RING_W-1:0]              ram_rdata
);

   localparam int PW = $clog2(QUEUE_SLOTS);

   typedef enum logic [3:0] {
      SQ_IDLE = 4'b0001,
      SQ_EMIT = 4'b0010,
      SQ_READ = 4'b0100,
      SQ_SEND = 4'b1000
   } seq_state_type;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   seq_state_type  seq_ff, seq_in;
   hs_state_type   hs_ff, hs_in;
   logic [PW-1:0]  head_ff, head_in, tail_ff, tail_in, tail_next;
   logic [7:0]     lrid_ff, lrid_in;
   logic [11:0]    cnt_ff, cnt_in;
   logic           armed_ff, armed_in;
   logic           prim_valid_ff, prim_valid_in;
   rsp_type        prim_data_ff, prim_data_in;
   logic           disp_ff, disp_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff, out_data_in;
   logic           out_free, want_dispatch, go_ready;
   logic [2:0]     rx_class;
   ring_entry_type wr_entry, rd_entry;

   assign req_stall = (seq_ff != SQ_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rx_class  = (req_data.rx_class > RX_OTHER) ? RX_OTHER : req_data.rx_class;
   assign tail_next = ptr_inc(tail_ff);
   assign rd_entry  = ring_entry_type'(ram_rdata);

   always_comb begin
      wr_entry.req_class = req_data.req_class;
      wr_entry.msg_param = req_data.msg_param;
      wr_entry.msg_id    = req_data.msg_id;
   end

   assign ram_wdata = RING_W'(wr_entry);
   assign ram_addr  = (seq_ff == SQ_READ) ? head_ff : tail_ff;
   assign ram_re    = (seq_ff == SQ_READ);

   always_comb begin
      seq_in        = seq_ff;
      hs_in         = hs_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      lrid_in       = lrid_ff;
      cnt_in        = cnt_ff;
      armed_in      = armed_ff;
      prim_valid_in = prim_valid_ff;
      prim_data_in  = prim_data_ff;
      disp_in       = disp_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_data_in   = out_data_ff;
      want_dispatch = 1'b0;
      go_ready      = 1'b0;
      ram_we        = 1'b0;

      unique case (seq_ff)
         SQ_IDLE: begin
            if (req_valid) begin
               prim_valid_in = 1'b0;
               prim_data_in  = '0;
               unique case (req_data.kind)
                  KIND_ENQUEUE: begin
                     if (tail_next == head_ff) begin
                        prim_valid_in          = 1'b1;
                        prim_data_in.out_kind  = OUT_OVERFLOW;
                        prim_data_in.out_id    = req_data.msg_id;
                        prim_data_in.out_param = req_data.msg_param;
                     end else begin
                        ram_we  = 1'b1;
                        tail_in = tail_next;
                     end
                     want_dispatch = (hs_ff == HS_READY);
                  end
                  KIND_MESSAGE: begin
                     if (rx_class == RX_ASYNC) begin
                        prim_valid_in          = 1'b1;
                        prim_data_in.out_kind  = OUT_ASYNC;
                        prim_data_in.out_id    = req_data.msg_id;
                        prim_data_in.out_param = req_data.msg_param;
                     end else begin
                        unique case (hs_ff)
                           HS_ACK: go_ready = 1'b1;
                           HS_RESP: begin
                              if (req_data.msg_id == lrid_ff) begin
                                 prim_valid_in          = 1'b1;
                                 prim_data_in.out_kind  = OUT_RESPONSE;
                                 prim_data_in.out_id    = lrid_ff;
                                 prim_data_in.out_param = req_data.msg_param;
                              end
                              go_ready = 1'b1;
                           end
                           HS_INIT: begin
                              if (rx_class == RX_INIT) begin
                                 go_ready = 1'b1;
                              end else if (rx_class == RX_ERROR) begin
                                 hs_in = HS_STUCK;
                              end
                           end
                           HS_SRC_ACK: begin
                              if (rx_class == RX_ACK) begin
                                 cnt_in   = cfg.source_settle;
                                 armed_in = 1'b1;
                                 hs_in    = HS_SRC_DELAY;
                              end else begin
                                 go_ready = 1'b1;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  KIND_TICK: begin
                     if (armed_ff) begin
                        if (cnt_ff <= 12'd1) begin
                           armed_in = 1'b0;
                           cnt_in   = 12'd0;
                           unique case (hs_ff)
                              HS_INIT: begin
                                 // init timed out: poll the device status
                                 prim_valid_in         = 1'b1;
                                 prim_data_in.out_kind = OUT_SEND;
                                 prim_data_in.out_id   = cfg.status_id;
                                 lrid_in               = cfg.status_id;
                                 cnt_in                = cfg.query_wait;
                                 armed_in              = 1'b1;
                                 hs_in                 = HS_RESP;
                              end
                              HS_ACK, HS_RESP, HS_SRC_ACK, HS_SRC_DELAY: go_ready = 1'b1;
                              default: ;
                           endcase
                        end else begin
                           cnt_in = cnt_ff - 12'd1;
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                  end
               endcase
               if (go_ready) begin
                  armed_in      = 1'b0;
                  cnt_in        = 12'd0;
                  hs_in         = HS_READY;
                  want_dispatch = 1'b1;
               end
               disp_in = want_dispatch && (head_in != tail_in);
               if (prim_valid_in) begin
                  seq_in = SQ_EMIT;
               end else if (disp_in) begin
                  seq_in = SQ_READ;
               end
            end
         end
         SQ_EMIT: begin
            if (out_free) begin
               out_valid_in         = 1'b1;
               out_data_in          = prim_data_ff;
               out_data_in.out_last = !disp_ff;
               seq_in               = disp_ff ? SQ_READ : SQ_IDLE;
            end
         end
         SQ_READ: begin
            seq_in = SQ_SEND;
         end
         SQ_SEND: begin
            if (out_free) begin
               out_valid_in           = 1'b1;
               out_data_in.out_kind   = OUT_SEND;
               out_data_in.out_id     = rd_entry.msg_id;
               out_data_in.out_param  = rd_entry.msg_param;
               out_data_in.out_last   = 1'b1;
               head_in                = ptr_inc(head_ff);
               lrid_in                = rd_entry.msg_id;
               armed_in               = 1'b1;
               unique case (rd_entry.req_class)
                  CLASS_RESET: begin
                     out_data_in.out_feedback = 1'b0;
                     cnt_in                   = cfg.reset_wait;
                     hs_in                    = HS_INIT;
                  end
                  CLASS_SOURCE: begin
                     out_data_in.out_feedback = 1'b1;
                     cnt_in                   = cfg.ack_wait;
                     hs_in                    = HS_SRC_ACK;
                  end
                  CLASS_QUERY: begin
                     out_data_in.out_feedback = 1'b0;
                     cnt_in                   = cfg.query_wait;
                     hs_in                    = HS_RESP;
                  end
                  CLASS_PLAIN: begin
                     out_data_in.out_feedback = 1'b1;
                     cnt_in                   = cfg.ack_wait;
                     hs_in                    = HS_ACK;
                  end
               endcase
               seq_in = SQ_IDLE;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SQ_IDLE;
         hs_ff         <= HS_READY;
         head_ff       <= '0;
         tail_ff       <= '0;
         lrid_ff       <= 8'd0;
         cnt_ff        <= 12'd0;
         armed_ff      <= 1'b0;
         prim_valid_ff <= 1'b0;
         disp_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         hs_ff         <= hs_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         lrid_ff       <= lrid_in;
         cnt_ff        <= cnt_in;
         armed_ff      <= armed_in;
         prim_valid_ff <= prim_valid_in;
         disp_ff       <= disp_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prim_data_ff <= prim_data_in;
      out_data_ff  <= out_data_in;
   end

endmodule
`default_nettype wire

@@ hdl/command_queue_ack_sequencer_top.sv @@
// Top level of the command queue and acknowledgement sequencer.
// Flow: an item is taken while the sequencer is idle; a reported result (overflow, reply, async)
// is registered and leaves the result register from the EMIT state, and a command sent from
// the ring leaves from the SEND state after the READ state and after any earlier result, as the
// ring RAM read is registered. No new item is taken until these are out; an output stall holds them.
// Reset (synchronous): handshake ready, ring empty, timer disarmed, registers at defaults;
// ring contents stay undefined, and no clearing pass is run.
`default_nettype none
module command_queue_ack_sequencer_top
   import cqas_pkg::*;
#(
   parameter int QUEUE_SLOTS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input item channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   // result item channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   localparam int PW = $clog2(QUEUE_SLOTS);

   cfg_type           cfg;
   logic              ram_we, ram_re;
   logic [PW-1:0]     ram_addr;
   logic [RING_W-1:0] ram_wdata, ram_rdata;

   // wait lengths and the status query id
   cqas_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // pending command ring: written at the tail on enqueue, read at the head on dispatch;
   // the read never falls in the same cycle as a write, so no forwarding is needed
   cqas_ram #(
      .WIDTH (RING_W),
      .DEPTH (QUEUE_SLOTS)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // handshake control, timer, pointers and the result register
   cqas_seq #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg),
      .ram_we    (ram_we),
      .ram_re    (ram_re),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

endmodule
`default_nettype wire
